FILE: design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, payload structs and inter-module control words for the
// LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // capacity register
  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
  } rsp_t;

  // write side of the key/value memories
  typedef struct packed {
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      addr;
    logic [KEY_BITS-1:0]   key_data;
    logic [VALUE_BITS-1:0] val_data;
  } store_wr_t;

  // recency tracker commands; evict uses the tracker's own victim
  typedef struct packed {
    logic             touch;
    logic             evict;
    logic             insert;
    logic [IDX_W-1:0] slot;
  } rec_cmd_t;

endpackage

FILE: design/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Key and value memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lkvc_store
  import lkvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  store_wr_t             wr,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [KEY_BITS-1:0]   key_rd,
  output logic [VALUE_BITS-1:0] val_rd
);

  logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key_data;
    end
    if (wr.val_we) begin
      val_mem[wr.addr] <= wr.val_data;
    end
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
  end

  // scan and write-back phases never overlap
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr.key_we || wr.val_we) |-> !rd_en)
    else $error("store written during scan");

endmodule

FILE: design/lkvc_recency.sv
// ----------------------------------------------------------------------------
// lkvc_recency
// Valid bits, per-entry recency ranks (0 = most recent) and entry count.
// Picks the eviction victim and the lowest free slot.
// ----------------------------------------------------------------------------
module lkvc_recency
  import lkvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  rec_cmd_t               cmd,
  output logic [MAX_ENTRIES-1:0] valid,
  output logic [CNT_W-1:0]       count,
  output logic [IDX_W-1:0]       free_slot
);

  logic [IDX_W-1:0] rank [MAX_ENTRIES];
  logic [IDX_W-1:0] victim;
  logic [IDX_W-1:0] last_rank;
  logic [IDX_W-1:0] touch_rank;

  assign last_rank  = IDX_W'(count - CNT_W'(1));
  assign touch_rank = rank[cmd.slot];

  // lowest index wins
  always_comb begin
    victim    = '0;
    free_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && rank[i] == last_rank) begin
        victim = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid[i] && rank[i] < touch_rank) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      rank[cmd.slot] <= '0;
    end else if (cmd.evict) begin
      valid[victim] <= 1'b0;
      rank[victim]  <= '0;
      count         <= count - 1'b1;
    end else if (cmd.insert) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      valid[cmd.slot] <= 1'b1;
      rank[cmd.slot]  <= '0;
      count           <= count + 1'b1;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid)) == count)
    else $error("entry count out of step with valid bits");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !valid[cmd.slot])
    else $error("insert into occupied slot");

  a_touch_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.touch |-> valid[cmd.slot])
    else $error("touch of empty slot");

endmodule

FILE: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Sequence: accept, scan every entry, decide; a put of a new key then
//   inserts it, evicting the least recent entry first when full.
// Scan: one entry per cycle through the single read port of the key memory;
//   a new request is taken only once the last one is through (ready in idle).
// Reset: clears control, valid bits, ranks and count; capacity goes to 16.
//   Key and value memories are not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  // one-hot request sequencer
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_EVICT  = 6'b001000,
    S_INSERT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CAP_W-1:0]      cap;
  req_t                  req_q;
  rsp_t                  res;

  // scan pipeline: address issued, compare in the following cycle on memory data
  logic [IDX_W-1:0]      scan_addr;
  logic                  cmp_en;
  logic [IDX_W-1:0]      cmp_addr;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_slot;
  logic [VALUE_BITS-1:0] hit_value;

  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  match;
  logic                  hit_any;
  logic [IDX_W-1:0]      slot_any;
  logic [VALUE_BITS-1:0] value_any;

  logic [MAX_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       free_slot;
  logic [CNT_W-1:0]       cap_eff;
  logic                   full;
  logic                   is_put;

  store_wr_t wr;
  rec_cmd_t  rcmd;

  assign req_ready = (state == S_IDLE);
  assign is_put    = (req_q.req_type == REQ_PUT);

  // keys are unique among held entries, so at most one match per scan
  assign match = cmp_en && valid[cmp_addr] && (key_rd == req_q.lookup_key);

  // last entry's compare lands in the decide cycle: fold it in directly
  assign hit_any   = hit_q || match;
  assign slot_any  = match ? cmp_addr : hit_slot;
  assign value_any = match ? val_rd : hit_value;

  // capacity beyond the store size behaves as the store size
  assign cap_eff = ({{(32-CAP_W){1'b0}}, cap} > 32'(MAX_ENTRIES)) ?
                   CNT_W'(MAX_ENTRIES) : CNT_W'(cap);
  assign full    = (count >= cap_eff);

  // --- control ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    wr         = '0;
    rcmd       = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_addr == IDX_W'(MAX_ENTRIES - 1)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rcmd.touch    = hit_any;
        rcmd.slot     = slot_any;
        wr.val_we     = is_put && hit_any;
        wr.addr       = slot_any;
        wr.val_data   = req_q.write_value;
        if (!is_put || hit_any) begin
          state_next = S_DONE;
        end else if (full) begin
          // capacity zero with nothing held: the new pair is dropped
          state_next = (count == '0) ? S_DONE : S_EVICT;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_EVICT: begin
        rcmd.evict = 1'b1;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        rcmd.insert = 1'b1;
        rcmd.slot   = free_slot;
        wr.key_we   = 1'b1;
        wr.val_we   = 1'b1;
        wr.addr     = free_slot;
        wr.key_data = req_q.lookup_key;
        wr.val_data = req_q.write_value;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      cmp_en    <= 1'b0;
      hit_q     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == S_SCAN);
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (state == S_IDLE) begin
        hit_q <= 1'b0;
      end else if (match) begin
        hit_q <= 1'b1;
      end
      // response register frees the sequencer from the output side
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_addr <= scan_addr;
    if (state == S_IDLE) begin
      req_q     <= req;
      scan_addr <= '0;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (match) begin
      hit_slot  <= cmp_addr;
      hit_value <= val_rd;
    end
    if (state == S_DECIDE) begin
      res.found      <= hit_any;
      res.read_value <= (!is_put && hit_any) ? value_any : '0;
    end
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

  // --- datapath --------------------------------------------------------------
  lkvc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .key_rd  (key_rd),
    .val_rd  (val_rd)
  );

  lkvc_recency u_recency (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rcmd),
    .valid     (valid),
    .count     (count),
    .free_slot (free_slot)
  );

  // eviction only ever follows a decide with something held
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> (count != '0 && $past(state) == S_DECIDE))
    else $error("eviction with empty store");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU key-value cache. A short directed table
// covers the empty cache, the key and value extremes, updates, the zero and
// oversized capacities and eviction after the capacity is lowered. Random
// get/put traffic over small key pools follows, with several capacities and
// random stalls on both channels. Each response word is compared with a
// behavioural LRU model of the cache, or with the fixed word of a table row.
// ----------------------------------------------------------------------------
module testbench;
  import lkvc_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the pipe
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES  = 40;    // idle tail after the last owed word returns
  localparam int REPORT_MAX   = 10;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed table; want is only used when fixed is set
  typedef struct packed {
    row_kind_t        kind;
    req_t             word;
    logic [CAP_W-1:0] cap;
    logic             fixed;
    rsp_t             want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_ready;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  lru_key_value_cache dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Cache model. Age 0 is the most recent entry; live entries always carry
  // the ages 0..live_count-1.
  // --------------------------------------------------------------------------
  bit [KEY_BITS-1:0]   slot_key   [MAX_ENTRIES];
  bit [VALUE_BITS-1:0] slot_value [MAX_ENTRIES];
  bit                  slot_live  [MAX_ENTRIES];
  int unsigned         slot_age   [MAX_ENTRIES];
  int unsigned         live_count = 0;
  int unsigned         capacity   = CAP_RESET;

  rsp_t        replies_due [$];   // response words still owed by the cache
  stim_row_t   dir_rows [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_rsp = 1'b0;
  int          fault_count = 0;
  int          quiet_cycles = 0;

  // bring slot s to the front; only entries more recent than it get older
  function automatic void promote(int s);
    int i;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (slot_live[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic rsp_t cache_access(req_t w);
    rsp_t        res;
    int          hit;
    int          victim;
    int          spare;
    int          i;
    int unsigned room;
    res    = '0;
    hit    = -1;
    victim = -1;
    spare  = -1;
    // anything above the store size behaves as the store size
    room   = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
    for (i = MAX_ENTRIES - 1; i >= 0; i--)
      if (slot_live[i] && slot_key[i] == w.lookup_key) hit = i;
    res.found = (hit >= 0);
    if (hit >= 0) begin
      if (w.req_type == REQ_GET) res.read_value = slot_value[hit];
      else slot_value[hit] = w.write_value;
      promote(hit);
      return res;
    end
    if (w.req_type == REQ_GET) return res;
    // new key: evict first so that a free slot always exists
    if (live_count + 1 > room) begin
      // empty cache with no room: the new pair would be its own victim
      if (live_count == 0) return res;
      for (i = 0; i < MAX_ENTRIES; i++)
        if (slot_live[i] && slot_age[i] == live_count - 1) victim = i;
      slot_live[victim] = 1'b0;
      slot_age[victim]  = 0;
      live_count--;
    end
    for (i = MAX_ENTRIES - 1; i >= 0; i--)
      if (!slot_live[i]) spare = i;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (slot_live[i]) slot_age[i]++;
    slot_key[spare]   = w.lookup_key;
    slot_value[spare] = w.write_value;
    slot_live[spare]  = 1'b1;
    slot_age[spare]   = 0;
    live_count++;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic stim_row_t word_row(logic op, logic [KEY_BITS-1:0] key,
                                         logic [VALUE_BITS-1:0] val, logic fixed,
                                         logic hit, logic [VALUE_BITS-1:0] got);
    stim_row_t row;
    row                  = '0;
    row.kind             = ROW_REQ;
    row.word.req_type    = op;
    row.word.lookup_key  = key;
    row.word.write_value = val;
    row.fixed            = fixed;
    row.want.found       = hit;
    row.want.read_value  = got;
    return row;
  endfunction

  function automatic stim_row_t cap_row(logic [CAP_W-1:0] c);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cap  = c;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid is raised regardless of ready and held with the word
  // steady until the handshake; the expectation is booked at acceptance.
  // --------------------------------------------------------------------------
  task automatic send_word(req_t w, logic fixed, rsp_t fixed_want);
    rsp_t model_says;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    model_says = cache_access(w);
    replies_due.push_back(fixed ? fixed_want : model_says);
  endtask

  // capacity only changes with the cache drained: every owed word returned
  task automatic write_capacity(logic [CAP_W-1:0] c);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity = c;
  endtask

  // random traffic: mostly keys from a pool a bit larger than the capacity,
  // so hits, updates and evictions all come up; some fresh and extreme keys
  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned s_pct,
                           int unsigned r_pct, int n, int pool_size, bit squeeze);
    bit [KEY_BITS-1:0] pool [$];
    req_t              w;
    int unsigned       pick;
    int                k;
    write_capacity(cap);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (k = 0; k < pool_size; k++) pool.push_back($urandom());
    if (squeeze) hold_rsp = 1'b1;
    for (k = 0; k < n; k++) begin
      pick       = $urandom_range(0, 99);
      w.req_type = $urandom_range(0, 1) ? REQ_PUT : REQ_GET;
      if (pick < 85) w.lookup_key = pool[$urandom_range(0, pool_size - 1)];
      else if (pick < 95) w.lookup_key = $urandom();
      else w.lookup_key = pick[0] ? '1 : '0;
      if ($urandom_range(0, 15) == 0) w.write_value = $urandom_range(0, 1) ? '1 : '0;
      else w.write_value = $urandom();
      send_word(w, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rsp_drive
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic log_fault(string why, rsp_t want);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display("%0t: %s: want found=%0b value=%08h, got found=%0b value=%08h",
               $time, why, want.found, want.read_value, rsp.found, rsp.read_value);
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (replies_due.size() == 0) begin
        log_fault("response word with nothing outstanding", '0);
      end else begin
        want = replies_due.pop_front();
        if (rsp.found !== want.found) log_fault("found differs", want);
        else if (rsp.read_value !== want.read_value) log_fault("read_value differs", want);
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT - 1) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 33;
    recv_idle_pct = 46;

    // straight out of reset the cache is empty
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0));
    // zero capacity on an empty cache: the put is dropped on arrival
    dir_rows.push_back(cap_row(5'd0));
    dir_rows.push_back(word_row(REQ_PUT, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 32'h0));
    // largest register value, acts as a full-size store
    dir_rows.push_back(cap_row(5'd31));
    dir_rows.push_back(word_row(REQ_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0));
    // get ignores its write value
    dir_rows.push_back(word_row(REQ_GET, 32'hFFFF_FFFF, 32'h1357_9BDF, 1'b1, 1'b1,
                                32'hFFFF_FFFF));
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0));
    // update of a held key: found, but a put never returns data
    dir_rows.push_back(word_row(REQ_PUT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
    // capacity lowered under the count: held entries stay, one out per insert
    dir_rows.push_back(cap_row(5'd1));
    dir_rows.push_back(word_row(REQ_PUT, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_PUT, 32'h8000_0000, 32'h8000_0001, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h5A5A_5A5A, 32'h0, 1'b0, 1'b0, 32'h0));
    // back to full size, then squeeze to check the eviction order
    dir_rows.push_back(cap_row(5'd16));
    dir_rows.push_back(word_row(REQ_PUT, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_PUT, 32'hFFFF_FFFE, 32'h0000_1234, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(cap_row(5'd3));
    dir_rows.push_back(word_row(REQ_PUT, 32'h0000_00FF, 32'hFEDC_BA98, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0));
    dir_rows.push_back(word_row(REQ_GET, 32'h0000_0001, 32'h0, 1'b0, 1'b0, 32'h0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_CFG) write_capacity(dir_rows[r].cap);
      else send_word(dir_rows[r].word, dir_rows[r].fixed, dir_rows[r].want);
    end

    // sender idles more lightly than the receiver first
    run_phase(5'd16, 33, 46, 350, 24, 1'b0);
    run_phase(5'd4,  33, 46, 250,  7, 1'b0);
    run_phase(5'd0,  33, 46, 150,  4, 1'b0);   // zero capacity with entries held
    // then the other way round
    run_phase(5'd31, 46, 33, 350, 20, 1'b0);
    run_phase(5'd1,  46, 33, 200,  3, 1'b0);
    // no idling; the first of these opens with the long receiver hold-off
    run_phase(5'd9,   0,  0, 300, 14, 1'b1);
    run_phase(5'd17,  0,  0, 150, 40, 1'b0);

    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lkvc_pkg.sv
design/lkvc_store.sv
design/lkvc_recency.sv
design/lru_key_value_cache.sv
tb/testbench.sv
